### hdl/brb_pkg.sv
package brb_pkg;

    localparam int MSG_W    = 32;
    localparam int CLIENT_W = 3;

    // request kinds
    localparam logic [1:0] K_WRITE  = 2'd0;
    localparam logic [1:0] K_READ   = 2'd1;
    localparam logic [1:0] K_ADD    = 2'd2;
    localparam logic [1:0] K_REMOVE = 2'd3;

    // response status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BUSY   = 2'd1;
    localparam logic [1:0] ST_NACK   = 2'd2;
    localparam logic [1:0] ST_CLIENT = 2'd3;

    typedef struct packed {
        logic [1:0]          kind;
        logic [CLIENT_W-1:0] client;
        logic [MSG_W-1:0]    message;
    } t_req;

    typedef struct packed {
        logic [1:0]       status;
        logic [MSG_W-1:0] read_data;
    } t_rsp;

    // controller -> datapath
    typedef struct packed {
        logic capture;  // latch the accepted request
        logic exec;     // carry out the latched request
        logic drain;    // one drain step of a reader removal
        logic clear;    // one step of the pending-count clearing pass
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic more;        // removal still has unread slots after this step
        logic clear_last;  // clearing pass at its final slot
        logic out_free;    // response register can take a result this cycle
    } t_dp_sts;

endpackage

### hdl/brb_ctrl.sv
module brb_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_stall,
    input  brb_pkg::t_dp_sts i_sts,
    output brb_pkg::t_dp_cmd o_cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_LOOK  = 3'd2;
    localparam logic [2:0] S_EXEC  = 3'd3;
    localparam logic [2:0] S_DRD   = 3'd4;
    localparam logic [2:0] S_DWR   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_LOOK;
                end
            end
            S_LOOK: begin
                // memory reads settle here; hold until the result has a home
                if (i_sts.out_free) n_state = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_sts.more ? S_DRD : S_IDLE;
            end
            S_DRD: begin
                n_state = S_DWR;
            end
            S_DWR: begin
                o_cmd.drain = 1'b1;
                n_state     = i_sts.more ? S_DRD : S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign o_req_stall = (r_state != S_IDLE);

endmodule

### hdl/brb_dp.sv
module brb_dp #(
    parameter int SLOTS      = 16,
    parameter int CLIENTS    = 8,
    parameter int DATA_WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  brb_pkg::t_req    i_req,
    input  brb_pkg::t_dp_cmd i_cmd,
    output brb_pkg::t_dp_sts o_sts,
    output logic             o_rsp_valid,
    output brb_pkg::t_rsp    o_rsp,
    input  logic             i_rsp_stall
);

    localparam int AW = $clog2(SLOTS);
    localparam int CW = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
    localparam int UW = $clog2(SLOTS + 1);
    localparam int PW = $clog2(CLIENTS + 1);

    // latched request
    logic [1:0]                   r_kind;
    logic [brb_pkg::CLIENT_W-1:0] r_client;
    logic [DATA_WIDTH-1:0]        r_msg;

    // ring and reader state
    logic [DATA_WIDTH-1:0] mem_msg  [SLOTS];
    logic [PW-1:0]         mem_pend [SLOTS];
    logic [AW-1:0]         r_wp;
    logic [PW-1:0]         r_act_cnt;
    logic [CLIENTS-1:0]    r_active;
    logic [AW-1:0]         r_pos    [CLIENTS];
    logic [UW-1:0]         r_unread [CLIENTS];
    logic [AW-1:0]         r_clr;

    // registered memory reads
    logic [PW-1:0]         r_pend_a;
    logic [PW-1:0]         r_pend_b;
    logic [DATA_WIDTH-1:0] r_msg_b;

    logic                  r_rsp_valid;
    brb_pkg::t_rsp         r_rsp;

    logic [CW-1:0]         w_ci;
    logic                  w_cok;
    logic                  w_act;
    logic [AW-1:0]         w_rpos;
    logic [UW-1:0]         w_unr;
    logic [AW-1:0]         w_rpos_nxt;
    logic [AW-1:0]         w_wp_nxt;
    logic [PW-1:0]         w_pend_dec;
    logic                  w_do_write;
    logic                  w_do_add;
    logic                  w_do_consume;
    logic                  w_do_deact;
    logic                  w_more;
    logic [1:0]            w_status;
    logic [DATA_WIDTH-1:0] w_data;
    logic                  w_load;
    logic                  w_pw_en;
    logic [AW-1:0]         w_pw_addr;
    logic [PW-1:0]         w_pw_data;

    assign w_ci       = CW'(r_client);
    assign w_cok      = (32'(r_client) < 32'(CLIENTS));
    assign w_act      = w_cok && r_active[w_ci];
    assign w_rpos     = w_cok ? r_pos[w_ci] : '0;
    assign w_unr      = w_cok ? r_unread[w_ci] : '0;
    assign w_rpos_nxt = (w_rpos == AW'(SLOTS - 1)) ? '0 : w_rpos + AW'(1);
    assign w_wp_nxt   = (r_wp == AW'(SLOTS - 1)) ? '0 : r_wp + AW'(1);
    assign w_pend_dec = (r_pend_b != '0) ? r_pend_b - PW'(1) : '0;

    always_comb begin
        w_do_write   = 1'b0;
        w_do_add     = 1'b0;
        w_do_consume = 1'b0;
        w_do_deact   = 1'b0;
        w_more       = 1'b0;
        w_status     = brb_pkg::ST_OK;
        w_data       = '0;
        if (i_cmd.exec) begin
            if (r_kind == brb_pkg::K_WRITE) begin
                if (r_pend_a != '0) w_status = brb_pkg::ST_BUSY;
                else                w_do_write = 1'b1;
            end else if (!w_cok) begin
                w_status = brb_pkg::ST_CLIENT;
            end else if (r_kind == brb_pkg::K_READ) begin
                if (!w_act) begin
                    w_status = brb_pkg::ST_CLIENT;
                end else if (w_unr == '0) begin
                    w_status = brb_pkg::ST_NACK;
                end else begin
                    w_do_consume = 1'b1;
                    w_data       = r_msg_b;
                end
            end else if (r_kind == brb_pkg::K_ADD) begin
                if (w_act) w_status = brb_pkg::ST_CLIENT;
                else       w_do_add = 1'b1;
            end else begin
                if (!w_act) begin
                    w_status = brb_pkg::ST_CLIENT;
                end else if (w_unr == '0) begin
                    w_do_deact = 1'b1;
                end else begin
                    w_do_consume = 1'b1;
                    w_more       = (w_unr > UW'(1));
                    w_do_deact   = !w_more;
                end
            end
        end else if (i_cmd.drain) begin
            w_do_consume = 1'b1;
            w_more       = (w_unr > UW'(1));
            w_do_deact   = !w_more;
        end
    end

    assign w_load = (i_cmd.exec || i_cmd.drain) && !w_more;

    // single write port of the pending store
    always_comb begin
        w_pw_en   = 1'b0;
        w_pw_addr = r_wp;
        w_pw_data = r_act_cnt;
        if (i_cmd.clear) begin
            w_pw_en   = 1'b1;
            w_pw_addr = r_clr;
            w_pw_data = '0;
        end else if (w_do_write) begin
            w_pw_en   = 1'b1;
        end else if (w_do_consume) begin
            w_pw_en   = 1'b1;
            w_pw_addr = w_rpos;
            w_pw_data = w_pend_dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pw_en) mem_pend[w_pw_addr] <= w_pw_data;
        if (w_do_write) mem_msg[r_wp] <= r_msg;
        r_pend_a <= mem_pend[r_wp];
        r_pend_b <= mem_pend[w_rpos];
        r_msg_b  <= mem_msg[w_rpos];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind   <= i_req.kind;
            r_client <= i_req.client;
            r_msg    <= DATA_WIDTH'(i_req.message);
        end
        if (w_load) begin
            r_rsp.status    <= w_status;
            r_rsp.read_data <= brb_pkg::MSG_W'(w_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_act_cnt   <= '0;
            r_active    <= '0;
            r_clr       <= '0;
            r_rsp_valid <= 1'b0;
            for (int i = 0; i < CLIENTS; i++) begin
                r_pos[i]    <= '0;
                r_unread[i] <= '0;
            end
        end else begin
            if (i_cmd.clear) r_clr <= r_clr + AW'(1);
            if (w_do_write) r_wp <= w_wp_nxt;
            if (w_do_add) begin
                r_act_cnt <= r_act_cnt + PW'(1);
            end else if (w_do_deact && r_act_cnt != '0) begin
                r_act_cnt <= r_act_cnt - PW'(1);
            end
            for (int i = 0; i < CLIENTS; i++) begin
                if (w_do_write && r_active[i]) r_unread[i] <= r_unread[i] + UW'(1);
                if (CW'(i) == w_ci) begin
                    if (w_do_consume) begin
                        r_pos[i]    <= w_rpos_nxt;
                        r_unread[i] <= w_unr - UW'(1);
                    end
                    if (w_do_add) begin
                        r_active[i] <= 1'b1;
                        r_pos[i]    <= r_wp;
                        r_unread[i] <= '0;
                    end
                    if (w_do_deact) begin
                        r_active[i] <= 1'b0;
                        r_unread[i] <= '0;
                    end
                end
            end
            if (w_load)                          r_rsp_valid <= 1'b1;
            else if (r_rsp_valid && !i_rsp_stall) r_rsp_valid <= 1'b0;
        end
    end

    assign o_sts.more       = w_more;
    assign o_sts.clear_last = (r_clr == AW'(SLOTS - 1));
    assign o_sts.out_free   = !r_rsp_valid || !i_rsp_stall;
    assign o_rsp_valid      = r_rsp_valid;
    assign o_rsp            = r_rsp;

endmodule

### hdl/broadcast_ring_buffer.sv
// Each request is captured, looked up in the registered memory reads, then
//   executed into the response register; the next request is stalled until
//   it is done. A reader removal takes one read-then-write pass per drained slot.
// Reset: synchronous, active low. Afterwards the pending counts are cleared
//   one slot a cycle, during which requests are stalled.
module broadcast_ring_buffer #(
    parameter int SLOTS      = 16,
    parameter int CLIENTS    = 8,
    parameter int DATA_WIDTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_stall,
    input  brb_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_stall,
    output brb_pkg::t_rsp o_rsp
);

    // Control and status between the sequencer and the datapath.
    brb_pkg::t_dp_cmd w_cmd;
    brb_pkg::t_dp_sts w_sts;

    // Sequencer: clearing pass, request capture, a look-up state for the
    // registered memory reads, execution, and the drain loop of a removal.
    // It holds a request in the look-up state until the response register
    // is free, so a result still waiting there is never overwritten; while
    // it waits, the next transaction waits with it.
    brb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // Datapath: message and pending-count memories (the pending store has
    // two read ports, at the write position and at the reader's position,
    // and one write port), the per-reader registers and the response
    // register.
    brb_dp #(
        .SLOTS      (SLOTS),
        .CLIENTS    (CLIENTS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp),
        .i_rsp_stall (i_rsp_stall)
    );

    // Reset always leads into the clearing pass, so requests are held off.
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_req_stall)
        else $error("request not stalled during clearing pass");

    // One transaction at a time: a taken request stalls the next.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && !o_req_stall) |=> o_req_stall)
        else $error("second request taken while one is in flight");

    // A result only appears while a request is being worked on.
    a_result_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp_valid) |-> $past(o_req_stall))
        else $error("result produced with no request in flight");

endmodule
